// ===== hdl/gdp_pkg.sv =====
// Package for the grid path finder: grid constants, codes and shared types.
// No dependencies.
package gdp_pkg;
	localparam int GRID_W_DEF = 8;
	localparam int GRID_H_DEF = 8;
	localparam int DIM_W = 4;
	localparam int CELL_AW = 6;
	localparam int CELLS = 64;
	localparam logic [7:0] UNREACHED = 8'd255;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FIND = 1'b1;

	localparam logic [1:0] CODE_WALL = 2'd1;

	localparam logic [1:0] ST_STEP = 2'd0;
	localparam logic [1:0] ST_AT_START = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [2:0] cell_x;
		logic [2:0] cell_y;
		logic [1:0] cell_value;
		logic [1:0] target_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] step_x;
		logic [2:0] step_y;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN, S_SCAN_END, S_CHECK, S_RELAX, S_RELAX_WR,
		S_TRACE, S_EMIT, S_STATUS
	} state_t;
endpackage

// ===== hdl/gdp_if.sv =====
// Valid/ready stream interfaces for the path finder.
// Depends on gdp_pkg.
interface gdp_in_if;
	logic valid;
	logic ready;
	gdp_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface gdp_out_if;
	logic valid;
	logic ready;
	gdp_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/gdp_ram.sv =====
// One-write one-read synchronous memory, registered read data.
// No dependencies.
module gdp_ram #(
	parameter int DW = 8,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/grid_dijkstra_path_finder_unit.sv =====
// Grid path finder top level: cell map, search stores and the search sequencer.
// Depends on gdp_pkg, gdp_if and gdp_ram.
//
// Channels: in (write or find items), out (path steps or one status result),
// plus a write port for map_width (index 0) and map_height (index 1).
// A write item is written to the cell map when taken and gives no result.
// A find runs Dijkstra on the per-cell store memory: an init sweep of one cell
// a cycle over all 64 cells, then rounds until the target is settled or no
// reachable cell is left, each a scan of the W*H cells at one cell a cycle,
// a pick step, a settle step, and a read and a write step per neighbour.
// The path is then traced back through the store's predecessor fields into a
// stack memory, a read and a write step per cell, then emitted start-first,
// once the first step is fetched, one step a cycle while the receiver is ready.
// A new item is taken only after the last result of a find has transferred.
// A stalled receiver holds the result steady; the search waits.
// Reset clears the cell map with a sweep over its 64 cells, sets width and
// height to 8, and empties the sequencer; no item is taken during the sweep.
module grid_dijkstra_path_finder_unit #(
	parameter int GRID_W = gdp_pkg::GRID_W_DEF,
	parameter int GRID_H = gdp_pkg::GRID_H_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	gdp_in_if.sink                  in,
	gdp_out_if.source               out,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [gdp_pkg::DIM_W-1:0] cfg_data
);
	localparam int AW = gdp_pkg::CELL_AW;

	gdp_pkg::state_t st_q, st_d;
	logic [3:0] w_q, h_q;
	logic clr_q;
	logic [AW:0] clr_cnt_q;

	logic [2:0] cx_q, cy_q;
	logic [AW-1:0] start_q, best_q, best_pred_q;
	logic [7:0] bd_q;
	logic best_vld_q;
	logic [1:0] tgt_q;
	logic [2:0] nb_q;
	logic [AW:0] cnt_q;
	logic [AW:0] n_q, k_q;
	logic [AW-1:0] cur_q;
	logic [1:0] stat_q;
	logic emit_vld_q;
	logic scan_rd_vld_q;
	logic [AW-1:0] scan_addr_q;

	// per-cell store: {settled, distance, predecessor}
	logic ds_we;
	logic [AW-1:0] ds_wa, ds_ra;
	logic [14:0] ds_wd, ds_rd;
	logic cm_we;
	logic [AW-1:0] cm_wa, cm_ra;
	logic [1:0] cm_wd, cm_rd;
	logic tr_we;
	logic [AW-1:0] tr_wa, tr_ra, tr_rd;

	gdp_ram #(.DW(15), .AW(AW)) u_store (.clk, .we(ds_we), .waddr(ds_wa),
		.wdata(ds_wd), .raddr(ds_ra), .rdata(ds_rd));
	gdp_ram #(.DW(2), .AW(AW)) u_map (.clk, .we(cm_we), .waddr(cm_wa),
		.wdata(cm_wd), .raddr(cm_ra), .rdata(cm_rd));
	gdp_ram #(.DW(AW), .AW(AW)) u_trail (.clk, .we(tr_we), .waddr(tr_wa),
		.wdata(cur_q), .raddr(tr_ra), .rdata(tr_rd));

	function automatic logic [3:0] clamp(input logic [3:0] v, input int hi);
		if (v < 4'd2) return 4'd2;
		if (32'(v) > hi) return 4'(hi);
		return v;
	endfunction

	function automatic logic [AW-1:0] idx(input logic [2:0] x, input logic [2:0] y);
		return {y, x};
	endfunction

	// neighbour offsets
	logic signed [4:0] nx, ny;
	logic nb_ok, nb_diag;
	logic [2:0] bx, by;
	assign bx = best_q[2:0];
	assign by = best_q[5:3];
	always_comb begin
		logic signed [1:0] dx, dy;
		unique case (nb_q)
			3'd0: begin dx = -2'sd1; dy = -2'sd1; end
			3'd1: begin dx = -2'sd1; dy = 2'sd0; end
			3'd2: begin dx = -2'sd1; dy = 2'sd1; end
			3'd3: begin dx = 2'sd0; dy = -2'sd1; end
			3'd4: begin dx = 2'sd0; dy = 2'sd1; end
			3'd5: begin dx = 2'sd1; dy = -2'sd1; end
			3'd6: begin dx = 2'sd1; dy = 2'sd0; end
			3'd7: begin dx = 2'sd1; dy = 2'sd1; end
		endcase
		nx = 5'(signed'({2'b00, bx})) + 5'(dx);
		ny = 5'(signed'({2'b00, by})) + 5'(dy);
		nb_diag = (dx != 2'sd0) && (dy != 2'sd0);
		nb_ok = (nx >= 0) && (ny >= 0) && (nx < signed'({1'b0, w_q}))
			&& (ny < signed'({1'b0, h_q}));
	end
	logic [AW-1:0] nc;
	assign nc = idx(nx[2:0], ny[2:0]);

	logic [8:0] nd;
	logic [7:0] ndc;
	assign nd = {1'b0, bd_q} + (nb_diag ? 9'd2 : 9'd1);
	assign ndc = (nd > 9'd254) ? 8'd254 : nd[7:0];

	logic out_fire;
	assign out_fire = out.valid && out.ready;
	logic scan_last;
	assign scan_last = (cx_q == 3'(w_q - 4'd1)) && (cy_q == 3'(h_q - 4'd1));
	logic scan_hit;
	assign scan_hit = scan_rd_vld_q && !ds_rd[14] && ds_rd[13:6] != gdp_pkg::UNREACHED
		&& ds_rd[13:6] <= bd_q;

	assign tr_we = (st_q == gdp_pkg::S_TRACE) && cnt_q[0];
	assign tr_wa = n_q[AW-1:0];
	assign tr_ra = (st_q == gdp_pkg::S_EMIT && out_fire) ? 6'(k_q - 7'd2)
		: 6'(k_q - 7'd1);

	assign in.ready = (st_q == gdp_pkg::S_IDLE) && !clr_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			gdp_pkg::S_IDLE: if (in.valid && in.ready && in.data.operation == gdp_pkg::OP_FIND)
				st_d = (in.data.cell_x >= 3'(w_q) && w_q < 4'd8) ||
					(in.data.cell_y >= 3'(h_q) && h_q < 4'd8) ?
					gdp_pkg::S_STATUS : gdp_pkg::S_INIT;
			gdp_pkg::S_INIT: if (cnt_q == 7'(gdp_pkg::CELLS - 1)) st_d = gdp_pkg::S_SCAN;
			gdp_pkg::S_SCAN: if (scan_last) st_d = gdp_pkg::S_SCAN_END;
			gdp_pkg::S_SCAN_END: st_d = gdp_pkg::S_CHECK;
			gdp_pkg::S_CHECK: begin
				if (!best_vld_q) st_d = gdp_pkg::S_STATUS;
				else if (cm_rd == tgt_q)
					st_d = (best_q == start_q) ? gdp_pkg::S_STATUS : gdp_pkg::S_TRACE;
				else st_d = gdp_pkg::S_RELAX;
			end
			gdp_pkg::S_RELAX: st_d = gdp_pkg::S_RELAX_WR;
			gdp_pkg::S_RELAX_WR: if (nb_q == 3'd7) st_d = gdp_pkg::S_SCAN;
				else st_d = gdp_pkg::S_RELAX;
			gdp_pkg::S_TRACE: if (cnt_q[0] && (ds_rd[AW-1:0] == start_q ||
				n_q == 7'(gdp_pkg::CELLS - 2))) st_d = gdp_pkg::S_EMIT;
			gdp_pkg::S_EMIT: if (out_fire && k_q == 7'd1) st_d = gdp_pkg::S_IDLE;
			gdp_pkg::S_STATUS: if (out_fire) st_d = gdp_pkg::S_IDLE;
			default: st_d = gdp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ds_we = 1'b0; ds_wa = '0; ds_wd = '0; ds_ra = idx(cx_q, cy_q);
		cm_we = 1'b0; cm_wa = '0; cm_wd = '0; cm_ra = best_q;
		if (clr_q) begin
			cm_we = 1'b1; cm_wa = clr_cnt_q[AW-1:0];
		end else if (st_q == gdp_pkg::S_IDLE && in.valid
			&& in.data.operation == gdp_pkg::OP_WRITE) begin
			cm_we = 1'b1; cm_wa = idx(in.data.cell_x, in.data.cell_y);
			cm_wd = in.data.cell_value;
		end
		unique case (st_q)
			gdp_pkg::S_INIT: begin
				ds_we = 1'b1; ds_wa = cnt_q[AW-1:0];
				ds_wd = {1'b0, (cnt_q[AW-1:0] == start_q) ? 8'd0 : gdp_pkg::UNREACHED,
					6'd0};
			end
			gdp_pkg::S_SCAN_END: cm_ra = scan_hit ? scan_addr_q : best_q;
			gdp_pkg::S_CHECK: if (best_vld_q) begin
				ds_we = 1'b1; ds_wa = best_q; ds_wd = {1'b1, bd_q, best_pred_q};
			end
			gdp_pkg::S_RELAX: begin
				ds_ra = nc; cm_ra = nc;
			end
			gdp_pkg::S_RELAX_WR: begin
				if (nb_ok && !ds_rd[14] && cm_rd != gdp_pkg::CODE_WALL
					&& ndc < ds_rd[13:6]) begin
					ds_we = 1'b1; ds_wa = nc; ds_wd = {1'b0, ndc, best_q};
				end
			end
			gdp_pkg::S_TRACE: ds_ra = cur_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gdp_pkg::S_IDLE;
			w_q <= clamp(4'd8, GRID_W);
			h_q <= clamp(4'd8, GRID_H);
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 7'd1;
				if (clr_cnt_q == 7'(gdp_pkg::CELLS - 1)) clr_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == gdp_pkg::CFG_WIDTH) w_q <= clamp(cfg_data, GRID_W);
				else h_q <= clamp(cfg_data, GRID_H);
			end
		end
	end

	// scan compare on the previous cycle's read
	always_ff @(posedge clk) begin
		scan_rd_vld_q <= (st_q == gdp_pkg::S_SCAN);
		scan_addr_q <= idx(cx_q, cy_q);
		emit_vld_q <= (st_q == gdp_pkg::S_EMIT);
		if (scan_hit) begin
			bd_q <= ds_rd[13:6]; best_q <= scan_addr_q; best_pred_q <= ds_rd[AW-1:0];
			best_vld_q <= 1'b1;
		end
		unique case (st_q)
			gdp_pkg::S_IDLE: if (in.valid && in.ready) begin
				start_q <= idx(in.data.cell_x, in.data.cell_y);
				tgt_q <= in.data.target_value;
				cnt_q <= '0;
				stat_q <= gdp_pkg::ST_NONE;
			end
			gdp_pkg::S_INIT: begin
				cnt_q <= cnt_q + 7'd1;
				cx_q <= '0; cy_q <= '0; bd_q <= gdp_pkg::UNREACHED; best_vld_q <= 1'b0;
			end
			gdp_pkg::S_SCAN: begin
				if (cy_q == 3'(h_q - 4'd1)) begin
					cy_q <= '0; cx_q <= cx_q + 3'd1;
				end else cy_q <= cy_q + 3'd1;
			end
			gdp_pkg::S_CHECK: begin
				nb_q <= '0; cx_q <= '0; cy_q <= '0;
				cur_q <= best_q; n_q <= '0; cnt_q <= '0;
				stat_q <= (best_vld_q && best_q == start_q) ? gdp_pkg::ST_AT_START
					: gdp_pkg::ST_NONE;
			end
			gdp_pkg::S_RELAX_WR: begin
				nb_q <= nb_q + 3'd1;
				if (nb_q == 3'd7) begin
					bd_q <= gdp_pkg::UNREACHED; best_vld_q <= 1'b0;
				end
			end
			gdp_pkg::S_TRACE: begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q[0]) begin
					n_q <= n_q + 7'd1;
					k_q <= n_q + 7'd1;
					cur_q <= ds_rd[AW-1:0];
				end
			end
			gdp_pkg::S_EMIT: if (out_fire) k_q <= k_q - 7'd1;
			default: ;
		endcase
	end

	logic [AW-1:0] ec;
	assign ec = tr_rd;
	always_comb begin
		out.valid = 1'b0;
		out.data = '0;
		if (st_q == gdp_pkg::S_EMIT) begin
			out.valid = emit_vld_q;
			out.data.step_x = ec[2:0];
			out.data.step_y = ec[5:3];
			out.data.status = gdp_pkg::ST_STEP;
			out.data.last = (k_q == 7'd1);
		end else if (st_q == gdp_pkg::S_STATUS) begin
			out.valid = 1'b1;
			out.data.status = stat_q;
			out.data.last = 1'b1;
		end
	end
endmodule

// ===== bench/gdp_bench_pkg.sv =====
// Path prediction for the grid path finder bench: cell map, dimensions and search.
// Depends on gdp_pkg.
package gdp_bench_pkg;
	import gdp_pkg::*;

	logic [1:0] grid_codes [CELLS];
	int unsigned cols_in_use;
	int unsigned rows_in_use;

	function automatic int unsigned clamp_dim(logic [3:0] v);
		if (v < 2) return 2;
		if (v > 8) return 8;
		return v;
	endfunction

	function automatic void grid_clear();
		foreach (grid_codes[i]) grid_codes[i] = 2'd0;
		cols_in_use = 8;
		rows_in_use = 8;
	endfunction

	function automatic void set_dim(logic idx, logic [3:0] v);
		if (idx == CFG_WIDTH) cols_in_use = clamp_dim(v);
		else rows_in_use = clamp_dim(v);
	endfunction

	function automatic out_item_t mk_step(int x, int y, logic [1:0] st, logic lst);
		out_item_t r;
		r.step_x = x[2:0];
		r.step_y = y[2:0];
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	// Apply one item: a write updates the map, a find appends the steps it produces.
	function automatic void predict_path(in_item_t it, ref out_item_t steps[$]);
		int reach_cost [CELLS];
		bit done [CELLS];
		int pred [CELLS];
		int trail [$];
		int start, found, best, bd, nx, ny, nc, nd, cur;
		if (it.operation == OP_WRITE) begin
			grid_codes[it.cell_y * 8 + it.cell_x] = it.cell_value;
			return;
		end
		if (it.cell_x >= cols_in_use || it.cell_y >= rows_in_use) begin
			steps = {steps, mk_step(0, 0, ST_NONE, 1'b1)};
			return;
		end
		foreach (reach_cost[i]) begin
			reach_cost[i] = 255;
			done[i] = 0;
			pred[i] = 0;
		end
		start = it.cell_y * 8 + it.cell_x;
		reach_cost[start] = 0;
		found = -1;
		for (int r = 0; r < cols_in_use * rows_in_use; r++) begin
			best = -1;
			bd = 255;
			for (int cx = 0; cx < cols_in_use; cx++)
				for (int cy = 0; cy < rows_in_use; cy++)
					if (!done[cy*8+cx] && reach_cost[cy*8+cx] != 255
						&& reach_cost[cy*8+cx] <= bd) begin
						bd = reach_cost[cy*8+cx];
						best = cy * 8 + cx;
					end
			if (best < 0) break;
			done[best] = 1;
			if (grid_codes[best] == it.target_value) begin
				found = best;
				break;
			end
			for (int dx = -1; dx <= 1; dx++)
				for (int dy = -1; dy <= 1; dy++) begin
					nx = best % 8 + dx;
					ny = best / 8 + dy;
					if (dx == 0 && dy == 0) continue;
					if (nx < 0 || ny < 0 || nx >= cols_in_use || ny >= rows_in_use) continue;
					nc = ny * 8 + nx;
					if (done[nc] || grid_codes[nc] == CODE_WALL) continue;
					nd = bd + ((dx != 0 && dy != 0) ? 2 : 1);
					if (nd > 254) nd = 254;
					if (nd < reach_cost[nc]) begin
						reach_cost[nc] = nd;
						pred[nc] = best;
					end
				end
		end
		if (found < 0) begin
			steps = {steps, mk_step(0, 0, ST_NONE, 1'b1)};
			return;
		end
		if (found == start) begin
			steps = {steps, mk_step(0, 0, ST_AT_START, 1'b1)};
			return;
		end
		cur = found;
		while (cur != start && trail.size() < 63) begin
			trail.push_front(cur);
			cur = pred[cur];
		end
		foreach (trail[k])
			steps = {steps, mk_step(trail[k] % 8, trail[k] / 8, ST_STEP,
				k == trail.size() - 1)};
	endfunction
endpackage

// ===== bench/grid_dijkstra_path_finder_unit_test.sv =====
// Bench top for the grid path finder: random cell writes and finds, queued driver,
// monitor checking every path step against the predicted path.
// Depends on gdp_pkg, gdp_if, gdp_bench_pkg and the block.
module grid_dijkstra_path_finder_unit_test;
	import gdp_pkg::*;
	import gdp_bench_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [3:0] cfg_data = 4'd0;

	gdp_in_if in_ch();
	gdp_out_if out_ch();

	grid_dijkstra_path_finder_unit dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	in_item_t pending_items [$];
	out_item_t expected_steps [$];
	int errors = 0;
	int idle_pct = 35;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit stall_on = 1'b0;

	initial in_ch.valid = 1'b0;
	initial in_ch.data = '0;
	initial out_ch.ready = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			predict_path(in_ch.data, expected_steps);
			void'(pending_items.pop_front());
		end
		if ((!in_ch.valid || in_ch.ready) && arst_n) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_items[0];
			end else begin
				in_ch.valid <= 1'b0;
				in_ch.data <= '0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_steps.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, out_ch.data);
			end else begin
				if (out_ch.data !== expected_steps[0]) begin
					errors++;
					$display("%0t: mismatch, expected %p, actual %p", $time,
						expected_steps[0], out_ch.data);
				end
				void'(expected_steps.pop_front());
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (stall_on) begin
			stall_on <= 1'b0;
			stall_left <= 400;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n && ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 40000) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_cfg(logic idx, logic [3:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_dim(idx, v);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || expected_steps.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_item_t mk_item(logic op, int x, int y, int v, int t);
		in_item_t it;
		it.operation = op;
		it.cell_x = x[2:0];
		it.cell_y = y[2:0];
		it.cell_value = v[1:0];
		it.target_value = t[1:0];
		return it;
	endfunction

	function automatic void queue_item(in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	task automatic random_maze(int walls);
		for (int i = 0; i < walls; i++)
			queue_item(mk_item(OP_WRITE, $urandom_range(7), $urandom_range(7),
				($urandom_range(99) < 60) ? 1 : $urandom_range(3), 0));
		queue_item(mk_item(OP_WRITE, $urandom_range(7), $urandom_range(7), 2, 0));
	endtask

	initial begin
		grid_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (70) @(posedge clk);
		// Directed: open map, target at far corner, walls, diagonals, status cases.
		queue_item(mk_item(OP_WRITE, 7, 7, 2, 0));
		queue_item(mk_item(OP_FIND, 0, 0, 0, 2));
		queue_item(mk_item(OP_FIND, 7, 7, 0, 2));
		queue_item(mk_item(OP_WRITE, 3, 3, 1, 0));
		queue_item(mk_item(OP_WRITE, 4, 4, 1, 0));
		queue_item(mk_item(OP_FIND, 0, 0, 0, 2));
		queue_item(mk_item(OP_FIND, 3, 3, 0, 1));
		queue_item(mk_item(OP_FIND, 0, 0, 3, 1));
		queue_item(mk_item(OP_FIND, 4, 4, 0, 3));
		queue_item(mk_item(OP_WRITE, 0, 1, 3, 0));
		queue_item(mk_item(OP_FIND, 0, 0, 0, 3));
		queue_item(mk_item(OP_FIND, 5, 5, 0, 0));
		drain();
		write_cfg(CFG_WIDTH, 4'd15);
		write_cfg(CFG_HEIGHT, 4'd0);
		queue_item(mk_item(OP_FIND, 0, 3, 0, 2));
		queue_item(mk_item(OP_FIND, 7, 1, 0, 3));
		queue_item(mk_item(OP_WRITE, 6, 6, 2, 0));
		drain();
		write_cfg(CFG_WIDTH, 4'd3);
		write_cfg(CFG_HEIGHT, 4'd5);
		queue_item(mk_item(OP_WRITE, 2, 4, 2, 0));
		queue_item(mk_item(OP_FIND, 0, 0, 0, 2));
		drain();
		// Random phases on differing map sizes.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 0 : 35;
			write_cfg(CFG_WIDTH, (ph == 3) ? 4'd8 : 4'($urandom_range(2, 8)));
			write_cfg(CFG_HEIGHT, (ph == 3) ? 4'd8 : 4'($urandom_range(2, 8)));
			for (int k = 0; k < 5; k++) begin
				random_maze($urandom_range(1, 4));
				queue_item(mk_item(OP_FIND, $urandom_range(7), $urandom_range(7),
					$urandom_range(3), ($urandom_range(99) < 70) ? 2 : $urandom_range(3)));
			end
			if (ph == 2) stall_on = 1'b1;
			drain();
		end
		idle_pct = 35;
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
